FILE: hw/rtl/ac_zero_cross_phase_tracker_unit_assert.svh
// Assertion macros for the zero-cross phase tracker.
`ifndef AC_ZERO_CROSS_PHASE_TRACKER_UNIT_ASSERT_SVH
`define AC_ZERO_CROSS_PHASE_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication
`define AZ_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AZ_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ac_zct_pkg.sv
// Package: shared constants and types of the zero-cross phase tracker.
`timescale 1ns / 1ps
package ac_zct_pkg;

  localparam int PERIOD_W   = 20;
  localparam int TS_W       = 32;
  localparam int PW_W       = 16;
  localparam int DIVIDEND_W = 21;

  localparam int UPDATE_INTERVAL_LOG2_DEF = 8;
  localparam int AVERAGE_SHIFT_DEF        = 5;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 20'hFFFFF;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd10000;
  localparam logic [TS_W-1:0]     WAIT_LIMIT   = 32'd40000;

  localparam logic [1:0] MODE_PRESS   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [PERIOD_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [PERIOD_W-1:0] rem;
  } div_sts_t;

endpackage

FILE: hw/rtl/ac_zct_if.sv
// Handshake interfaces for the input and result words.
`timescale 1ns / 1ps
interface ac_zct_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic [ac_zct_pkg::TS_W-1:0]     timestamp_us;
  logic [ac_zct_pkg::PW_W-1:0]     pulse_width_ms;
  logic [ac_zct_pkg::PERIOD_W-1:0] relay_delay_us;

  modport source (output valid, mode, timestamp_us, pulse_width_ms, relay_delay_us,
                  input ready);
  modport sink (input valid, mode, timestamp_us, pulse_width_ms, relay_delay_us,
                output ready);
endinterface

interface ac_zct_out_if;
  logic                            valid;
  logic                            ready;
  logic                            wait_valid;
  logic [ac_zct_pkg::PERIOD_W-1:0] wait_us;
  logic [ac_zct_pkg::PERIOD_W-1:0] period_us;
  logic [ac_zct_pkg::PW_W-1:0]     pulse_width;
  logic [ac_zct_pkg::TS_W-1:0]     edge_count;

  modport source (output valid, wait_valid, wait_us, period_us, pulse_width, edge_count,
                  input ready);
  modport sink (input valid, wait_valid, wait_us, period_us, pulse_width, edge_count,
                output ready);
endinterface

FILE: hw/rtl/ac_zero_cross_phase_tracker_unit.sv
// Top level: mains period tracker with zero-crossing wait prediction.
// Flow: an accepted word passes an execute state, then a done state that registers the
// result when the output is free; a wait query whose raw wait is negative and must be
// wrapped modulo the period first runs the remainder unit, one dividend bit a cycle over
// 21 bits. A new word is taken only after the previous result has been registered.
// Reset: synchronous; period 10000 us, edge count, last edge time and width zero.
`timescale 1ns / 1ps
`include "ac_zero_cross_phase_tracker_unit_assert.svh"
module ac_zero_cross_phase_tracker_unit #(
  parameter int UPDATE_INTERVAL_LOG2 = ac_zct_pkg::UPDATE_INTERVAL_LOG2_DEF,
  parameter int AVERAGE_SHIFT        = ac_zct_pkg::AVERAGE_SHIFT_DEF
) (
  input logic         clk,
  input logic         rst_n,
  ac_zct_in_if.sink   in_ch,
  ac_zct_out_if.source out_ch
);

  localparam int PW = ac_zct_pkg::PERIOD_W;
  localparam int TW = ac_zct_pkg::TS_W;
  localparam int AW = PW + AVERAGE_SHIFT + 2;
  localparam int XW = PW + 3;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0]                  mode_r;
  logic [TW-1:0]               ts_r;
  logic [ac_zct_pkg::PW_W-1:0] pw_r;
  logic [PW-1:0]               delay_r;

  logic [TW-1:0]               cnt_r, cnt_nxt;
  logic [PW-1:0]               period_r, period_nxt;
  logic [TW-1:0]               last_r, last_nxt;
  logic [ac_zct_pkg::PW_W-1:0] width_r, width_nxt;
  logic                        wvalid_r, wvalid_nxt;
  logic [PW-1:0]               wait_r, wait_nxt;

  logic                        out_valid_r;
  logic                        out_wvalid_r;
  logic [PW-1:0]               out_wait_r;
  logic [PW-1:0]               out_period_r;
  logic [ac_zct_pkg::PW_W-1:0] out_width_r;
  logic [TW-1:0]               out_cnt_r;

  logic [TW-1:0] el;
  logic [TW-1:0] cnt_inc;
  logic          chk;
  logic          discard;
  logic [AW-1:0] avg_sum;
  logic [AW-1:0] avg_np;
  logic          q_fail;
  logic [XW-1:0] xq;
  logic [XW-1:0] xneg;
  logic          out_free;

  ac_zct_pkg::div_req_t div_req;
  ac_zct_pkg::div_sts_t div_sts;

  ac_zct_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .sts  (div_sts)
  );

  assign el      = ts_r - last_r;
  assign cnt_inc = cnt_r + 1'b1;
  assign chk     = (cnt_r != '0) && (cnt_inc[UPDATE_INTERVAL_LOG2-1:0] == '0);
  assign discard = chk && ((el <= TW'(period_r >> 1)) || (el >= TW'({period_r, 1'b0})));

  // (p * (2^S - 1) + el) >> S; el < 2p here
  assign avg_sum = AW'({period_r, {AVERAGE_SHIFT{1'b0}}}) - AW'(period_r) + el[AW-1:0];
  assign avg_np  = avg_sum >> AVERAGE_SHIFT;

  assign q_fail = (cnt_r == '0) || (el > ac_zct_pkg::WAIT_LIMIT);
  assign xq     = XW'(period_r) - XW'(el[15:0]) - XW'(delay_r);
  assign xneg   = XW'(0) - xq;

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    period_nxt       = period_r;
    last_nxt         = last_r;
    width_nxt        = width_r;
    wvalid_nxt       = wvalid_r;
    wait_nxt         = wait_r;
    div_req.start    = 1'b0;
    div_req.dividend = xneg[ac_zct_pkg::DIVIDEND_W-1:0];
    div_req.divisor  = period_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        wvalid_nxt = 1'b0;
        wait_nxt   = '0;
        state_nxt  = S_DONE;
        case (mode_r)
          ac_zct_pkg::MODE_PRESS: begin
            cnt_nxt = cnt_inc;
            if (!discard) begin
              last_nxt = ts_r;
              if (chk) begin
                period_nxt = (avg_np > AW'(ac_zct_pkg::PERIOD_MAX)) ?
                             ac_zct_pkg::PERIOD_MAX : avg_np[PW-1:0];
              end
            end
          end
          ac_zct_pkg::MODE_RELEASE: begin
            width_nxt = pw_r;
          end
          ac_zct_pkg::MODE_QUERY: begin
            if (!q_fail) begin
              wvalid_nxt = 1'b1;
              if (period_r != '0) begin
                if (xq[XW-1]) begin
                  div_req.start = 1'b1;
                  state_nxt     = S_DIV;
                end else begin
                  wait_nxt = xq[PW-1:0];
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_DIV: begin
        if (div_sts.done) begin
          wait_nxt  = (div_sts.rem == '0) ? '0 : period_r - div_sts.rem;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      period_r    <= ac_zct_pkg::PERIOD_RESET;
      last_r      <= '0;
      width_r     <= '0;
      wvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      period_r <= period_nxt;
      last_r   <= last_nxt;
      width_r  <= width_nxt;
      wvalid_r <= wvalid_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wait_r <= wait_nxt;
    if (in_ch.valid && in_ch.ready) begin
      mode_r  <= in_ch.mode;
      ts_r    <= in_ch.timestamp_us;
      pw_r    <= in_ch.pulse_width_ms;
      delay_r <= in_ch.relay_delay_us;
    end
    if (state_r == S_DONE && out_free) begin
      out_wvalid_r <= wvalid_r;
      out_wait_r   <= wait_r;
      out_period_r <= period_r;
      out_width_r  <= width_r;
      out_cnt_r    <= cnt_r;
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.wait_valid = out_wvalid_r;
  assign out_ch.wait_us    = out_wait_r;
  assign out_ch.period_us  = out_period_r;
  assign out_ch.pulse_width = out_width_r;
  assign out_ch.edge_count = out_cnt_r;

  `AZ_ASSERT_IMPL(a_div_done_in_div, clk, rst_n, div_sts.done, state_r == S_DIV, "remainder done outside wrap state")
  `AZ_ASSERT_IMPL(a_div_nonzero, clk, rst_n, state_r == S_DIV, period_r != '0, "wrap with zero period")
  `AZ_ASSERT_IMPL(a_fail_zero_wait, clk, rst_n, out_ch.valid && !out_ch.wait_valid, out_ch.wait_us == '0, "failed query with nonzero wait")
  `AZ_ASSERT_NEXT(a_cnt_press_only, clk, rst_n, !(state_r == S_EXEC && mode_r == ac_zct_pkg::MODE_PRESS), $stable(cnt_r), "edge count moved without a press edge")

endmodule

FILE: hw/rtl/ac_zct_div.sv
// Restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps
module ac_zct_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ac_zct_pkg::div_req_t req,
  output ac_zct_pkg::div_sts_t sts
);

  localparam int CNT_W = $clog2(ac_zct_pkg::DIVIDEND_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(ac_zct_pkg::DIVIDEND_W - 1);

  logic                                busy_r;
  logic                                done_r;
  logic [CNT_W-1:0]                    cnt_r;
  logic [ac_zct_pkg::DIVIDEND_W-1:0]   num_r;
  logic [ac_zct_pkg::PERIOD_W-1:0]     den_r;
  logic [ac_zct_pkg::PERIOD_W-1:0]     rem_r;
  logic [ac_zct_pkg::PERIOD_W:0]       trial;
  logic [ac_zct_pkg::PERIOD_W:0]       diff;

  assign trial = {rem_r, num_r[ac_zct_pkg::DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        num_r  <= req.dividend;
        den_r  <= req.divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        // partial remainder stays below the divisor
        rem_r <= diff[ac_zct_pkg::PERIOD_W] ? trial[ac_zct_pkg::PERIOD_W-1:0]
                                            : diff[ac_zct_pkg::PERIOD_W-1:0];
        num_r <= {num_r[ac_zct_pkg::DIVIDEND_W-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.done = done_r;
  assign sts.rem  = rem_r;

endmodule
